@@ hdl/tacho_speed_pi_controller_unit_defines.svh @@
// assertion macros for the tachometer speed pi controller
// used by the top level, expects clk_i and rst_ni in scope
`ifndef TACHO_SPEED_PI_CONTROLLER_UNIT_DEFINES_SVH
`define TACHO_SPEED_PI_CONTROLLER_UNIT_DEFINES_SVH

// property that holds in every cycle out of reset
`define TSPC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("tspc check failed");

// property with an antecedent and a consequent in the next cycle
`define TSPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tspc check failed");

`endif

@@ hdl/tspc_pkg.sv @@
// shared types, codes and constants of the tachometer speed pi controller
// no dependencies
`default_nettype none

package tspc_pkg;

  localparam int DefRingDepth = 16;
  localparam int QDepth       = 2;
  localparam int EntryW       = 17;
  localparam int SumW         = 21;
  localparam int SpeedW       = 15;
  localparam int DriveW       = 24;
  localparam int ErrW         = 18;
  localparam int SetptW       = 17;
  localparam int CfgIdxW      = 4;
  localparam int CfgDataW     = 32;

  localparam logic [1:0] REQ_CAPTURE = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_CMD     = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_COEF_NOW    = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_COEF_PREV   = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_INTV    = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_GAP         = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_SPEED_SCALE = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_WATCHDOG    = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_REV_LIMIT   = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_REV_DRIVE   = 4'd7;

  typedef enum logic [1:0] {
    OP_CAPTURE,
    OP_TICK,
    OP_CMD,
    OP_NONE
  } op_kind_e;

  typedef struct packed {
    op_kind_e                  kind;
    logic [31:0]               ts;
    logic signed [SetptW-1:0]  setpt;
  } op_t;

  typedef struct packed {
    logic signed [31:0]        coef_now;
    logic signed [31:0]        coef_prev;
    logic [15:0]               min_intv;
    logic [19:0]               gap;
    logic [23:0]               speed_scale;
    logic [7:0]                watchdog;
    logic [15:0]               rev_limit;
    logic signed [DriveW-1:0]  rev_drive;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_PI_A,
    ST_PI_B,
    ST_PI_C,
    ST_OUT
  } back_state_e;

endpackage

`default_nettype wire

@@ hdl/tspc_front.sv @@
// front end: takes input transactions, decodes the request and clamps the setpoint
// depends on tspc_pkg
`default_nettype none

module tspc_front (
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [31:0]                timestamp_us_i,
  input  wire logic signed [17:0]         speed_cmd_mm_s_i,
  input  wire tspc_pkg::q_stat_t          q_stat_i,
  output logic                            push_o,
  output tspc_pkg::op_t                   op_o
);

  logic signed [tspc_pkg::SetptW-1:0] setpt_sat;

  // clamp to the 17-bit setpoint range
  always_comb begin
    if (speed_cmd_mm_s_i[17] != speed_cmd_mm_s_i[16]) begin
      setpt_sat = speed_cmd_mm_s_i[17] ? {1'b1, {(tspc_pkg::SetptW-1){1'b0}}}
                                       : {1'b0, {(tspc_pkg::SetptW-1){1'b1}}};
    end else begin
      setpt_sat = speed_cmd_mm_s_i[16:0];
    end
  end

  always_comb begin
    op_o.ts    = timestamp_us_i;
    op_o.setpt = setpt_sat;
    case (req_type_i)
      tspc_pkg::REQ_CAPTURE: op_o.kind = tspc_pkg::OP_CAPTURE;
      tspc_pkg::REQ_TICK:    op_o.kind = tspc_pkg::OP_TICK;
      tspc_pkg::REQ_CMD:     op_o.kind = tspc_pkg::OP_CMD;
      default:               op_o.kind = tspc_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

endmodule

`default_nettype wire

@@ hdl/tspc_fifo.sv @@
// short queue of decoded operations between front and back
// depends on tspc_pkg
`default_nettype none

module tspc_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tspc_pkg::op_t     push_data_i,
  input  wire logic              pop_i,
  output tspc_pkg::op_t          head_o,
  output tspc_pkg::q_stat_t      stat_o
);

  localparam int PtrW = (tspc_pkg::QDepth > 1) ? $clog2(tspc_pkg::QDepth) : 1;
  localparam int CntW = $clog2(tspc_pkg::QDepth + 1);

  tspc_pkg::op_t   mem_q [tspc_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(tspc_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(tspc_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(tspc_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/tspc_back.sv @@
// back end: interval ring walk, serial divide, pi controller and result register
// depends on tspc_pkg
`default_nettype none

module tspc_back #(
  parameter int RING_DEPTH = tspc_pkg::DefRingDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tspc_pkg::cfg_t                    cfg_i,
  input  wire tspc_pkg::op_t                     head_i,
  input  wire tspc_pkg::q_stat_t                 q_stat_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [tspc_pkg::SpeedW-1:0]            speed_mm_s_o,
  output logic                                   drive_valid_o,
  output logic signed [tspc_pkg::DriveW-1:0]     drive_command_o
);

  localparam int IdxW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CntW  = $clog2(RING_DEPTH + 1);
  localparam int NumW  = 24 + CntW;
  localparam int DcntW = $clog2(NumW + 1);
  localparam int SumW  = tspc_pkg::SumW;
  localparam int EntW  = tspc_pkg::EntryW;
  localparam int ErrW  = tspc_pkg::ErrW;
  localparam int DrvW  = tspc_pkg::DriveW;
  localparam int SpdW  = tspc_pkg::SpeedW;
  localparam int ProdW = 32 + ErrW;
  localparam logic signed [DrvW+11:0] DrvMax = (DrvW+12)'(36'sd8388607);
  localparam logic signed [DrvW+11:0] DrvMin = (DrvW+12)'(-36'sd8388608);

  tspc_pkg::back_state_e state_q, state_d;

  // control state
  logic [EntW-1:0]          ring_q [RING_DEPTH];
  logic [RING_DEPTH-1:0]    ring_vld_q;
  logic [IdxW-1:0]          ring_idx_q;
  logic                     fresh_q;
  logic [SpdW-1:0]          measured_q;
  logic signed [DrvW-1:0]   prev_drive_q;
  logic signed [ErrW-1:0]   prev_err_q;
  logic [7:0]               ticks_q;
  logic signed [16:0]       setpt_q;
  logic [31:0]              last_cap_q;
  logic                     out_valid_q;

  // work registers
  tspc_pkg::op_t            op_q;
  logic [SumW-1:0]          sum_q;
  logic [CntW-1:0]          n_q;
  logic [IdxW-1:0]          walk_idx_q;
  logic [NumW-1:0]          num_q;
  logic [SumW-1:0]          rem_q;
  logic [DcntW-1:0]         div_cnt_q;
  logic signed [ProdW-1:0]  prod_a_q, prod_b_q;
  logic signed [ErrW-1:0]   err_q;
  logic                     sp_zero_q, rev_q;
  logic signed [DrvW-1:0]   drive_res_q;
  logic [SpdW-1:0]          out_speed_q;
  logic                     out_dvalid_q;
  logic signed [DrvW-1:0]   out_drive_q;

  logic                     out_load;

  // capture datapath
  logic [31:0]     gap;
  logic            gap_lt_min, gap_gt_win;
  logic [EntW-1:0] entry_sat, rd_entry;
  logic [SumW-1:0] sum_nx;
  logic [CntW-1:0] n_nx;
  logic            walk_end;
  logic [IdxW-1:0] idx_prev, idx_next;

  assign gap        = op_q.ts - last_cap_q;
  assign gap_lt_min = gap < {16'b0, cfg_i.min_intv};
  assign gap_gt_win = gap > {12'b0, cfg_i.gap};
  assign entry_sat  = (|gap[31:EntW]) ? {EntW{1'b1}} : gap[EntW-1:0];
  assign rd_entry   = ring_vld_q[walk_idx_q] ? ring_q[walk_idx_q] : '0;
  assign sum_nx     = sum_q + SumW'(rd_entry);
  assign n_nx       = n_q + 1'b1;
  assign walk_end   = (sum_nx >= SumW'(cfg_i.gap)) || (n_nx == CntW'(RING_DEPTH));
  assign idx_prev   = (walk_idx_q == '0) ? IdxW'(RING_DEPTH - 1) : walk_idx_q - 1'b1;
  assign idx_next   = (ring_idx_q == IdxW'(RING_DEPTH - 1)) ? '0 : ring_idx_q + 1'b1;

  // restoring divider step
  logic [SumW:0] rem_sh, rem_sub;
  logic          div_ge;
  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign div_ge  = rem_sh >= {1'b0, sum_q};
  assign rem_sub = rem_sh - {1'b0, sum_q};

  // controller datapath
  logic signed [16:0]        sp_eff;
  logic signed [ErrW-1:0]    sp18, cur18, err_sel, lim_neg;
  logic                      rev_cond;
  logic signed [ProdW:0]     acc;
  logic signed [ProdW-16:0]  acc_sh;
  logic signed [DrvW+11:0]   drv_sum;
  logic signed [DrvW-1:0]    drv_sat;

  assign sp_eff   = (ticks_q >= cfg_i.watchdog) ? '0 : setpt_q;
  assign sp18     = {sp_eff[16], sp_eff};
  assign cur18    = {3'b000, measured_q};
  assign lim_neg  = -$signed({2'b00, cfg_i.rev_limit});
  assign rev_cond = sp18 <= lim_neg;
  assign err_sel  = (sp_eff[16] && !rev_cond) ? sp18 + cur18 : sp18 - cur18;
  assign acc      = prod_a_q + prod_b_q;
  assign acc_sh   = acc[ProdW:16];
  assign drv_sum  = {{12{prev_drive_q[DrvW-1]}}, prev_drive_q}
                  + {{(DrvW+12-(ProdW-15)){acc_sh[ProdW-16]}}, acc_sh};

  always_comb begin
    if (drv_sum > DrvMax) begin
      drv_sat = {1'b0, {(DrvW-1){1'b1}}};
    end else if (drv_sum < DrvMin) begin
      drv_sat = {1'b1, {(DrvW-1){1'b0}}};
    end else begin
      drv_sat = drv_sum[DrvW-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tspc_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) state_d = tspc_pkg::ST_EXEC;
      end
      tspc_pkg::ST_EXEC: begin
        case (op_q.kind)
          tspc_pkg::OP_CAPTURE: begin
            state_d = (gap_lt_min || gap_gt_win) ? tspc_pkg::ST_OUT : tspc_pkg::ST_WALK;
          end
          tspc_pkg::OP_TICK: state_d = tspc_pkg::ST_PI_A;
          default:           state_d = tspc_pkg::ST_OUT;
        endcase
      end
      tspc_pkg::ST_WALK: begin
        if (rd_entry == '0) begin
          state_d = (sum_q != '0) ? tspc_pkg::ST_MUL : tspc_pkg::ST_OUT;
        end else if (walk_end) begin
          state_d = tspc_pkg::ST_MUL;
        end
      end
      tspc_pkg::ST_MUL:  state_d = tspc_pkg::ST_DIV;
      tspc_pkg::ST_DIV: begin
        if (div_cnt_q == DcntW'(1)) state_d = tspc_pkg::ST_SAT;
      end
      tspc_pkg::ST_SAT:  state_d = tspc_pkg::ST_OUT;
      tspc_pkg::ST_PI_A: state_d = tspc_pkg::ST_PI_B;
      tspc_pkg::ST_PI_B: state_d = tspc_pkg::ST_PI_C;
      tspc_pkg::ST_PI_C: state_d = tspc_pkg::ST_OUT;
      tspc_pkg::ST_OUT: begin
        if (out_load) state_d = tspc_pkg::ST_IDLE;
      end
      default: state_d = tspc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      tspc_pkg::ST_IDLE: pop_o    = !q_stat_i.empty;
      tspc_pkg::ST_OUT:  out_load = !out_valid_q || out_ready_i;
      default: begin
        pop_o    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tspc_pkg::ST_IDLE;
      ring_vld_q   <= '0;
      ring_idx_q   <= '0;
      fresh_q      <= 1'b0;
      measured_q   <= '0;
      prev_drive_q <= '0;
      prev_err_q   <= '0;
      ticks_q      <= '0;
      setpt_q      <= '0;
      last_cap_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tspc_pkg::ST_EXEC) begin
        case (op_q.kind)
          tspc_pkg::OP_CAPTURE: begin
            if (!gap_lt_min) begin
              last_cap_q <= op_q.ts;
              if (gap_gt_win) begin
                ring_vld_q <= '0;
                ring_idx_q <= '0;
              end else begin
                ring_vld_q[ring_idx_q] <= 1'b1;
                ring_idx_q             <= idx_next;
                fresh_q                <= 1'b1;
              end
            end
          end
          tspc_pkg::OP_TICK: begin
            if (ticks_q != 8'hff) ticks_q <= ticks_q + 1'b1;
            if (fresh_q) begin
              fresh_q <= 1'b0;
            end else begin
              measured_q   <= '0;
              prev_err_q   <= '0;
              prev_drive_q <= '0;
            end
          end
          tspc_pkg::OP_CMD: begin
            setpt_q <= op_q.setpt;
            ticks_q <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == tspc_pkg::ST_SAT) begin
        measured_q <= (|num_q[NumW-1:SpdW]) ? {SpdW{1'b1}} : num_q[SpdW-1:0];
      end
      if (state_q == tspc_pkg::ST_PI_C) begin
        prev_drive_q <= drv_sat;
        prev_err_q   <= err_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    if (pop_o) op_q <= head_i;
    if (state_q == tspc_pkg::ST_EXEC) begin
      // only a stored interval touches the ring
      if (op_q.kind == tspc_pkg::OP_CAPTURE && !gap_lt_min && !gap_gt_win) begin
        ring_q[ring_idx_q] <= entry_sat;
      end
      walk_idx_q         <= ring_idx_q;
      sum_q              <= '0;
      n_q                <= '0;
    end
    if (state_q == tspc_pkg::ST_WALK && rd_entry != '0) begin
      sum_q      <= sum_nx;
      n_q        <= n_nx;
      walk_idx_q <= idx_prev;
    end
    if (state_q == tspc_pkg::ST_MUL) begin
      num_q     <= NumW'(cfg_i.speed_scale) * NumW'(n_q);
      rem_q     <= '0;
      div_cnt_q <= DcntW'(NumW);
    end
    if (state_q == tspc_pkg::ST_DIV) begin
      rem_q     <= div_ge ? rem_sub[SumW-1:0] : rem_sh[SumW-1:0];
      num_q     <= {num_q[NumW-2:0], div_ge};
      div_cnt_q <= div_cnt_q - 1'b1;
    end
    if (state_q == tspc_pkg::ST_PI_A) begin
      err_q     <= err_sel;
      prod_a_q  <= cfg_i.coef_now * err_sel;
      sp_zero_q <= (sp_eff == '0);
      rev_q     <= rev_cond;
    end
    if (state_q == tspc_pkg::ST_PI_B) begin
      prod_b_q <= cfg_i.coef_prev * prev_err_q;
    end
    if (state_q == tspc_pkg::ST_PI_C) begin
      drive_res_q <= sp_zero_q ? '0 : (rev_q ? cfg_i.rev_drive : drv_sat);
    end
    if (out_load) begin
      out_speed_q  <= measured_q;
      out_dvalid_q <= (op_q.kind == tspc_pkg::OP_TICK);
      out_drive_q  <= (op_q.kind == tspc_pkg::OP_TICK) ? drive_res_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign speed_mm_s_o    = out_speed_q;
  assign drive_valid_o   = out_dvalid_q;
  assign drive_command_o = out_drive_q;

endmodule

`default_nettype wire

@@ hdl/tacho_speed_pi_controller_unit.sv @@
// top level of the tachometer speed pi controller: config registers, front, queue, back
// depends on tspc_pkg, tspc_front, tspc_fifo, tspc_back, tacho_speed_pi_controller_unit_defines.svh
//
// channel   direction  signals
// in        input      in_valid_i / in_ready_o, req_type_i, timestamp_us_i, speed_cmd_mm_s_i
// out       output     out_valid_o / out_ready_i, speed_mm_s_o, drive_valid_o, drive_command_o
// cfg       input      cfg_we_i, cfg_idx_i, cfg_data_i (write only, no wait)
//
// every transaction gives one result; commands and ignored captures go from exec straight to out
// a tick runs two registered multiplies and the drive add in the back end
// an accepted capture walks up to RING_DEPTH ring entries, then runs the serial divider,
// one quotient bit per cycle, before its result goes to out
// the queue holds two transactions, so input is still taken while a result waits on out, until the queue fills
// reset is asynchronous active low; the ring is cleared through valid bits, no sweep
`default_nettype none
`include "tacho_speed_pi_controller_unit_defines.svh"

module tacho_speed_pi_controller_unit #(
  parameter int RING_DEPTH = tspc_pkg::DefRingDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input transactions
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [31:0]                       timestamp_us_i,
  input  wire logic signed [17:0]                speed_cmd_mm_s_i,
  // result transactions
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [tspc_pkg::SpeedW-1:0]            speed_mm_s_o,
  output logic                                   drive_valid_o,
  output logic signed [tspc_pkg::DriveW-1:0]     drive_command_o,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [tspc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [tspc_pkg::CfgDataW-1:0]     cfg_data_i
);

  tspc_pkg::cfg_t     cfg_q;
  tspc_pkg::op_t      push_op, head_op;
  tspc_pkg::q_stat_t  q_stat;
  logic               push, pop;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_now    <= '0;
      cfg_q.coef_prev   <= '0;
      cfg_q.min_intv    <= 16'd300;
      cfg_q.gap         <= 20'd100000;
      cfg_q.speed_scale <= 24'd4937500;
      cfg_q.watchdog    <= 8'd100;
      cfg_q.rev_limit   <= 16'd2000;
      cfg_q.rev_drive   <= -24'sd655360;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tspc_pkg::REG_COEF_NOW:    cfg_q.coef_now    <= cfg_data_i;
        tspc_pkg::REG_COEF_PREV:   cfg_q.coef_prev   <= cfg_data_i;
        tspc_pkg::REG_MIN_INTV:    cfg_q.min_intv    <= cfg_data_i[15:0];
        tspc_pkg::REG_GAP:         cfg_q.gap         <= cfg_data_i[19:0];
        tspc_pkg::REG_SPEED_SCALE: cfg_q.speed_scale <= cfg_data_i[23:0];
        tspc_pkg::REG_WATCHDOG:    cfg_q.watchdog    <= cfg_data_i[7:0];
        tspc_pkg::REG_REV_LIMIT:   cfg_q.rev_limit   <= cfg_data_i[15:0];
        tspc_pkg::REG_REV_DRIVE:   cfg_q.rev_drive   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // decode and setpoint clamp
  tspc_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .timestamp_us_i   (timestamp_us_i),
    .speed_cmd_mm_s_i (speed_cmd_mm_s_i),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .op_o             (push_op)
  );

  // decouples decode from the long capture work
  tspc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .pop_i       (pop),
    .head_o      (head_op),
    .stat_o      (q_stat)
  );

  // ring walk, divider, controller and result register
  tspc_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (head_op),
    .q_stat_i        (q_stat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .speed_mm_s_o    (speed_mm_s_o),
    .drive_valid_o   (drive_valid_o),
    .drive_command_o (drive_command_o)
  );

  // non-tick results carry no drive
  `TSPC_ASSERT_ALWAYS(a_no_drive_off_tick, !(out_valid_o && !drive_valid_o) || drive_command_o == '0)
  // queue status never both full and empty
  `TSPC_ASSERT_ALWAYS(a_queue_status, !(q_stat.full && q_stat.empty))
  // an accepted transaction lands in the queue
  `TSPC_ASSERT_NEXT(a_push_lands, in_valid_i && in_ready_o, !q_stat.empty)

endmodule

`default_nettype wire
